### hdl/ferc_pkg.sv
// ferc_pkg: shared field widths and operation codes for the request cache
// no dependencies; used by the cache top level and its port checker
`timescale 1ns / 1ps

package ferc_pkg;

    localparam int MODE_BITS = 2;
    localparam int WIN_BITS  = 5;
    localparam int OCC_BITS  = 5;

    localparam logic [MODE_BITS-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_STORE  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd2;

    localparam logic [WIN_BITS-1:0] WINDOW_RESET = 5'd16;

    // register index of window_entries
    localparam logic REG_WINDOW = 1'b0;

endpackage

### hdl/fifo_evicting_request_cache_unit.sv
// fifo_evicting_request_cache_unit: key/value table with fifo replacement
// one transaction at a time; the result is registered in the apply state
// lookup and store sweep the keys through one shared comparator, stopping early on a hit
// clear and the unused mode skip the sweep; the next input is taken only once the state
// returns to idle after the result is registered, so a stall of the previous result holds it back
// rst_n is asynchronous, active low: all entries invalid, occupancy zero, window 16; depends on ferc_pkg
`timescale 1ns / 1ps

module fifo_evicting_request_cache_unit #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    // input stream
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // request_key, store_value
    input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0]    s_tdata,
    // mode
    input  logic [ferc_pkg::MODE_BITS-1:0]              s_tuser,
    // result stream
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // hit, found_value, inserted, occupancy
    output logic [((VALUE_BITS+ferc_pkg::OCC_BITS+2+7)/8)*8-1:0] m_tdata,
    // configuration
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [2:0]                                  paddr,
    input  logic [31:0]                                 pwdata,
    output logic [31:0]                                 prdata,
    output logic                                        pready
);

    localparam int OUT_W     = ((VALUE_BITS + ferc_pkg::OCC_BITS + 2 + 7) / 8) * 8;
    localparam int SLOT_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);
    localparam int SUM_W     = ((SLOT_BITS > ferc_pkg::OCC_BITS) ? SLOT_BITS
                                                                 : ferc_pkg::OCC_BITS) + 1;
    localparam int WIN_CAP   = (CAPACITY < 31) ? CAPACITY : 31;
    localparam logic [ferc_pkg::WIN_BITS-1:0] WIN_CAP_W = ferc_pkg::WIN_BITS'(WIN_CAP);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_APPLY} state_t;

    state_t                          state_reg;
    logic [ferc_pkg::WIN_BITS-1:0]   window_reg;
    logic [ferc_pkg::MODE_BITS-1:0]  mode_reg;
    logic [KEY_BITS-1:0]             key_reg;
    logic [VALUE_BITS-1:0]           val_reg;
    logic [CNT_BITS-1:0]             scan_cnt_reg;
    logic                            rd_pend_reg;
    logic                            vld_rd_reg;
    logic                            found_reg;
    logic [VALUE_BITS-1:0]           found_val_reg;
    logic [CAPACITY-1:0]             valid_reg;
    logic [SLOT_BITS-1:0]            oldest_reg;
    logic [ferc_pkg::OCC_BITS-1:0]   count_reg;
    logic                            m_tvalid_reg;
    logic                            hit_reg;
    logic [VALUE_BITS-1:0]           fval_reg;
    logic                            ins_reg;
    logic [ferc_pkg::OCC_BITS-1:0]   occ_reg;

    logic [KEY_BITS-1:0]             keys_mem [CAPACITY];
    logic [VALUE_BITS-1:0]           vals_mem [CAPACITY];
    logic [KEY_BITS-1:0]             key_rd_reg;
    logic [VALUE_BITS-1:0]           val_rd_reg;

    logic [SLOT_BITS-1:0]            scan_idx;
    logic                            scan_done;
    logic                            match;
    logic                            out_free;
    logic                            out_load;
    logic [ferc_pkg::WIN_BITS-1:0]   eff_win;
    logic                            store_ok;
    logic                            evict;
    logic [SLOT_BITS-1:0]            oldest_next;
    logic [ferc_pkg::OCC_BITS-1:0]   count_base;
    logic [ferc_pkg::OCC_BITS-1:0]   count_next;
    logic [CAPACITY-1:0]             valid_next;
    logic [SLOT_BITS-1:0]            wr_slot;
    logic                            mem_we;
    logic                            cfg_wr;

    function automatic logic [SLOT_BITS-1:0] wrap_slot(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = (s >= SUM_W'(CAPACITY)) ? (s - SUM_W'(CAPACITY)) : s;
        return t[SLOT_BITS-1:0];
    endfunction

    assign scan_idx  = scan_cnt_reg[SLOT_BITS-1:0];
    assign scan_done = (scan_cnt_reg == CNT_BITS'(CAPACITY));
    assign match     = rd_pend_reg && vld_rd_reg && (key_rd_reg == key_reg);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_wr    = psel && penable && pwrite && pready;

    always_comb
    begin
        eff_win  = (window_reg > WIN_CAP_W) ? WIN_CAP_W : window_reg;
        store_ok = (mode_reg == ferc_pkg::MODE_STORE) && !found_reg && (eff_win != '0);
        evict    = (count_reg >= eff_win) && (count_reg != '0);
        // oldest entry leaves first when the window is full
        if (evict)
        begin
            oldest_next = wrap_slot(SUM_W'(oldest_reg) + SUM_W'(1));
            count_base  = count_reg - 1'b1;
        end
        else
        begin
            oldest_next = oldest_reg;
            count_base  = count_reg;
        end
        wr_slot    = wrap_slot(SUM_W'(oldest_next) + SUM_W'(count_base));
        count_next = count_base + 1'b1;
        // set after clear: with a full ring the slots coincide
        valid_next = valid_reg;
        if (evict)
        begin
            valid_next[oldest_reg] = 1'b0;
        end
        valid_next[wr_slot] = 1'b1;
        out_load = (state_reg == ST_APPLY) && out_free;
        mem_we   = out_load && store_ok;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            keys_mem[wr_slot] <= key_reg;
            vals_mem[wr_slot] <= val_reg;
        end
        key_rd_reg <= keys_mem[scan_idx];
        val_rd_reg <= vals_mem[scan_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            window_reg   <= ferc_pkg::WINDOW_RESET;
            scan_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
            vld_rd_reg   <= 1'b0;
            found_reg    <= 1'b0;
            valid_reg    <= '0;
            oldest_reg   <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr && (paddr[2] == ferc_pkg::REG_WINDOW))
            begin
                window_reg <= pwdata[ferc_pkg::WIN_BITS-1:0];
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            vld_rd_reg <= valid_reg[scan_idx];

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        mode_reg     <= s_tuser;
                        key_reg      <= s_tdata[KEY_BITS-1:0];
                        val_reg      <= s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
                        scan_cnt_reg <= '0;
                        rd_pend_reg  <= 1'b0;
                        found_reg    <= 1'b0;
                        found_val_reg <= '0;
                        if ((s_tuser == ferc_pkg::MODE_LOOKUP) ||
                            (s_tuser == ferc_pkg::MODE_STORE))
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_APPLY;
                        end
                    end
                end
                ST_SCAN:
                begin
                    // read issued this cycle is compared in the next one
                    if (!scan_done)
                    begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                    rd_pend_reg <= !scan_done;
                    if (match)
                    begin
                        found_reg     <= 1'b1;
                        found_val_reg <= val_rd_reg;
                        state_reg     <= ST_APPLY;
                    end
                    else if (scan_done)
                    begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY:
                begin
                    if (out_free)
                    begin
                        hit_reg      <= (mode_reg == ferc_pkg::MODE_LOOKUP) && found_reg;
                        fval_reg     <= ((mode_reg == ferc_pkg::MODE_LOOKUP) && found_reg)
                                        ? found_val_reg : '0;
                        ins_reg      <= store_ok;
                        if (mode_reg == ferc_pkg::MODE_CLEAR)
                        begin
                            valid_reg  <= '0;
                            oldest_reg <= '0;
                            count_reg  <= '0;
                            occ_reg    <= '0;
                        end
                        else if (store_ok)
                        begin
                            valid_reg  <= valid_next;
                            oldest_reg <= oldest_next;
                            count_reg  <= count_next;
                            occ_reg    <= count_next;
                        end
                        else
                        begin
                            occ_reg <= count_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        m_tdata = '0;
        m_tdata[0] = hit_reg;
        m_tdata[VALUE_BITS:1] = fval_reg;
        m_tdata[VALUE_BITS+1] = ins_reg;
        m_tdata[VALUE_BITS+ferc_pkg::OCC_BITS+1:VALUE_BITS+2] = occ_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == ferc_pkg::REG_WINDOW)
                      ? {{(32-ferc_pkg::WIN_BITS){1'b0}}, window_reg} : 32'd0;

endmodule

### hdl/ferc_checker.sv
// ferc_checker: port-level assertions for the request cache, bound to its top level
// depends on ferc_pkg and fifo_evicting_request_cache_unit
`timescale 1ns / 1ps

module ferc_checker #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input logic                                        clk,
    input logic                                        rst_n,
    input logic                                        s_tvalid,
    input logic                                        s_tready,
    input logic                                        m_tvalid,
    input logic                                        m_tready,
    input logic [((VALUE_BITS+ferc_pkg::OCC_BITS+2+7)/8)*8-1:0] m_tdata
);

    localparam int OCC_LO = VALUE_BITS + 2;
    localparam int OCC_HI = VALUE_BITS + ferc_pkg::OCC_BITS + 1;

    // one transaction in flight: no new input right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while previous transaction in flight");

    // a lookup hit never reports an insertion
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[VALUE_BITS+1]))
    else $error("hit and inserted both set");

    // a miss or non-lookup returns a zero value word
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[VALUE_BITS:1] == '0))
    else $error("found_value nonzero without hit");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

    // occupancy never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (int'(m_tdata[OCC_HI:OCC_LO]) <= CAPACITY))
    else $error("occupancy above capacity");

endmodule

bind fifo_evicting_request_cache_unit ferc_checker #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
) u_ferc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/fifo_evicting_request_cache_unit_tb.sv
// fifo_evicting_request_cache_unit_tb: self-checking bench for the fifo-evicting request cache
// directed table then random transactions under several window settings, with a built-in predictor
// depends on ferc_pkg and fifo_evicting_request_cache_unit
`timescale 1ns / 1ps

module fifo_evicting_request_cache_unit_tb;

    localparam int CAPACITY         = 16;
    localparam int KEY_BITS         = 64;
    localparam int VALUE_BITS       = 32;
    localparam int S_DATA_BITS      = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS      = ((VALUE_BITS + ferc_pkg::OCC_BITS + 2 + 7) / 8) * 8;
    localparam logic [ferc_pkg::MODE_BITS-1:0] MODE_UNUSED = 2'd3;
    localparam logic [2:0] WINDOW_ADDR = {ferc_pkg::REG_WINDOW, 2'b00};
    localparam int KEEP_WINDOW      = -1;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int NUM_PHASES       = 10;
    localparam int ITEMS_PER_PHASE  = 103;
    localparam int KEY_POOL_SIZE    = 24;

    typedef logic [KEY_BITS-1:0]            key_t;
    typedef logic [VALUE_BITS-1:0]          value_t;
    typedef logic [ferc_pkg::OCC_BITS-1:0]  occ_t;
    typedef logic [ferc_pkg::MODE_BITS-1:0] mode_t;

    typedef struct packed {
        logic   hit;
        value_t found_value;
        logic   inserted;
        occ_t   occupancy;
    } cache_response_t;

    typedef struct {
        int              window;
        mode_t           mode;
        key_t            key;
        value_t          value;
        bit              typed;
        cache_response_t resp;
    } directed_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata;     // request_key, store_value
    mode_t                  s_tuser;     // mode
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_BITS-1:0] m_tdata;     // hit, found_value, inserted, occupancy
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [2:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    // predictor state, a ring in insertion order
    key_t   cache_keys   [CAPACITY];
    value_t cache_values [CAPACITY];
    bit     cache_valid  [CAPACITY];
    int     head_slot;
    int     stored_count;
    int     window_setting;

    cache_response_t pending_responses[$];
    directed_row_t   directed_rows[$];
    key_t            key_pool[KEY_POOL_SIZE];
    int              phase_windows[NUM_PHASES] = '{16, 1, 31, 0, 5, 17, 2, 16, 9, 3};
    int              quiet_send;
    int              quiet_recv;
    int              idle_cycles;
    bit              mismatch_seen;

    fifo_evicting_request_cache_unit #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 2 ns period
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // mostly short gaps, a few long ones, and now and then a stretch with none
    function automatic int pick_gap(inout int quiet_left);
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic cache_response_t predict_cache_response(
        input mode_t  mode,
        input key_t   key,
        input value_t value
    );
        cache_response_t resp;
        int match;
        int win;
        int slot;
        resp  = '0;
        match = CAPACITY;
        for (int i = CAPACITY - 1; i >= 0; i--)
            if (cache_valid[i] && cache_keys[i] == key)
                match = i;
        case (mode)
            ferc_pkg::MODE_LOOKUP:
            begin
                if (match < CAPACITY)
                begin
                    resp.hit         = 1'b1;
                    resp.found_value = cache_values[match];
                end
            end
            ferc_pkg::MODE_STORE:
            begin
                win = (window_setting > CAPACITY) ? CAPACITY : window_setting;
                if (win != 0 && match == CAPACITY)
                begin
                    // one eviction per insert, even if the window shrank below occupancy
                    if (stored_count >= win && stored_count > 0)
                    begin
                        cache_valid[head_slot] = 1'b0;
                        head_slot              = (head_slot + 1) % CAPACITY;
                        stored_count--;
                    end
                    slot               = (head_slot + stored_count) % CAPACITY;
                    cache_keys[slot]   = key;
                    cache_values[slot] = value;
                    cache_valid[slot]  = 1'b1;
                    stored_count++;
                    resp.inserted = 1'b1;
                end
            end
            ferc_pkg::MODE_CLEAR:
            begin
                foreach (cache_valid[i])
                    cache_valid[i] = 1'b0;
                head_slot    = 0;
                stored_count = 0;
            end
            default:
            begin
            end
        endcase
        resp.occupancy = occ_t'(stored_count);
        return resp;
    endfunction

    function automatic void add_row(
        input int     window,
        input mode_t  mode,
        input key_t   key,
        input value_t value,
        input bit     typed,
        input logic   hit,
        input value_t found_value,
        input logic   inserted,
        input int     occupancy
    );
        directed_row_t row;
        row.window = window;
        row.mode   = mode;
        row.key    = key;
        row.value  = value;
        row.typed  = typed;
        row.resp   = '{hit, found_value, inserted, occ_t'(occupancy)};
        directed_rows = {directed_rows, row};
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_request(
        input mode_t           mode,
        input key_t            key,
        input value_t          value,
        input bit              typed,
        input cache_response_t typed_resp
    );
        int gap;
        cache_response_t predicted;
        gap = pick_gap(quiet_send);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= S_DATA_BITS'({value, key});
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_cache_response(mode, key, value);
        pending_responses = {pending_responses, (typed ? typed_resp : predicted)};
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // write window_entries, then read it back
    task automatic set_window(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_ADDR;
        pwdata  <= 32'(value[ferc_pkg::WIN_BITS-1:0]);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        window_setting = value & ((1 << ferc_pkg::WIN_BITS) - 1);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== 32'(window_setting))
        begin
            $error("window_entries: expected %0d, actual %0d", window_setting, prdata);
            mismatch_seen = 1'b1;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side backpressure
    initial
    begin
        int stall;
        m_tready = 1'b0;
        quiet_recv = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = pick_gap(quiet_recv);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        cache_response_t want;
        logic            got_hit;
        value_t          got_value;
        logic            got_inserted;
        occ_t            got_occupancy;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_hit       = m_tdata[0];
            got_value     = m_tdata[VALUE_BITS:1];
            got_inserted  = m_tdata[VALUE_BITS+1];
            got_occupancy = m_tdata[VALUE_BITS+2 +: ferc_pkg::OCC_BITS];
            if (pending_responses.size() == 0)
            begin
                $error("unexpected result transaction: hit %0d found_value %h occupancy %0d",
                       got_hit, got_value, got_occupancy);
                mismatch_seen = 1'b1;
            end
            else
            begin
                want = pending_responses[0];
                pending_responses.delete(0);
                if (got_hit !== want.hit)
                begin
                    $error("hit: expected %0d, actual %0d", want.hit, got_hit);
                    mismatch_seen = 1'b1;
                end
                if (got_value !== want.found_value)
                begin
                    $error("found_value: expected %h, actual %h", want.found_value, got_value);
                    mismatch_seen = 1'b1;
                end
                if (got_inserted !== want.inserted)
                begin
                    $error("inserted: expected %0d, actual %0d", want.inserted, got_inserted);
                    mismatch_seen = 1'b1;
                end
                if (got_occupancy !== want.occupancy)
                begin
                    $error("occupancy: expected %0d, actual %0d", want.occupancy, got_occupancy);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // ends the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        mode_t  mode;
        key_t   key;
        value_t value;
        int     r;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idle_cycles   = 0;
        quiet_send    = 0;
        mismatch_seen = 1'b0;
        foreach (cache_valid[i])
            cache_valid[i] = 1'b0;
        head_slot      = 0;
        stored_count   = 0;
        window_setting = int'(ferc_pkg::WINDOW_RESET);

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        // extremes, every mode, duplicates, eviction, disabled and oversized windows
        add_row(KEEP_WINDOW, ferc_pkg::MODE_LOOKUP, '0, '0, 1, 0, '0, 0, 0);
        add_row(KEEP_WINDOW, ferc_pkg::MODE_STORE, '0, '0, 1, 0, '0, 1, 1);
        add_row(KEEP_WINDOW, ferc_pkg::MODE_STORE, '1, '1, 1, 0, '0, 1, 2);
        add_row(KEEP_WINDOW, ferc_pkg::MODE_LOOKUP, '1, '0, 1, 1, '1, 0, 2);
        add_row(KEEP_WINDOW, ferc_pkg::MODE_LOOKUP, '0, '1, 1, 1, '0, 0, 2);
        add_row(KEEP_WINDOW, ferc_pkg::MODE_STORE, '1, 32'h1234_5678, 1, 0, '0, 0, 2);
        add_row(KEEP_WINDOW, ferc_pkg::MODE_LOOKUP, '1, '0, 1, 1, '1, 0, 2);
        add_row(KEEP_WINDOW, MODE_UNUSED, '1, '1, 1, 0, '0, 0, 2);
        add_row(KEEP_WINDOW, ferc_pkg::MODE_CLEAR, '1, '1, 1, 0, '0, 0, 0);
        add_row(KEEP_WINDOW, ferc_pkg::MODE_LOOKUP, '1, '0, 1, 0, '0, 0, 0);
        add_row(2, ferc_pkg::MODE_STORE, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA,
                0, 0, '0, 0, 0);
        add_row(KEEP_WINDOW, ferc_pkg::MODE_STORE, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555,
                0, 0, '0, 0, 0);
        add_row(KEEP_WINDOW, ferc_pkg::MODE_STORE, 64'h8000_0000_0000_0001, 32'h8000_0001,
                0, 0, '0, 0, 0);
        add_row(KEEP_WINDOW, ferc_pkg::MODE_LOOKUP, 64'h5555_5555_5555_5555, '0,
                0, 0, '0, 0, 0);
        add_row(KEEP_WINDOW, ferc_pkg::MODE_LOOKUP, 64'h8000_0000_0000_0001, '0,
                0, 0, '0, 0, 0);
        add_row(0, ferc_pkg::MODE_STORE, 64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF,
                0, 0, '0, 0, 0);
        add_row(KEEP_WINDOW, ferc_pkg::MODE_LOOKUP, 64'h0123_4567_89AB_CDEF, '0,
                0, 0, '0, 0, 0);
        add_row(1, ferc_pkg::MODE_STORE, 64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF,
                0, 0, '0, 0, 0);
        add_row(KEEP_WINDOW, ferc_pkg::MODE_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '0,
                0, 0, '0, 0, 0);
        add_row(31, ferc_pkg::MODE_STORE, 64'hFEDC_BA98_7654_3210, 32'h0F0F_0F0F,
                0, 0, '0, 0, 0);
        add_row(KEEP_WINDOW, ferc_pkg::MODE_LOOKUP, 64'hFEDC_BA98_7654_3210, '0,
                0, 0, '0, 0, 0);
        add_row(16, ferc_pkg::MODE_LOOKUP, 64'h0123_4567_89AB_CDEF, '0, 0, 0, '0, 0, 0);
        add_row(KEEP_WINDOW, ferc_pkg::MODE_STORE, 64'h5555_5555_5555_5555, 32'hF0F0_F0F0,
                0, 0, '0, 0, 0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].window != KEEP_WINDOW)
            begin
                wait_idle();
                set_window(directed_rows[i].window);
            end
            send_request(directed_rows[i].mode, directed_rows[i].key, directed_rows[i].value,
                         directed_rows[i].typed, directed_rows[i].resp);
        end

        // state carries over between phases so shrinking windows meet a full table
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            set_window(phase_windows[p]);
            repeat (ITEMS_PER_PHASE)
            begin
                r = $urandom_range(0, 199);
                if (r < 90)
                    mode = ferc_pkg::MODE_LOOKUP;
                else if (r < 184)
                    mode = ferc_pkg::MODE_STORE;
                else if (r < 187)
                    mode = ferc_pkg::MODE_CLEAR;
                else
                    mode = MODE_UNUSED;
                if ($urandom_range(0, 99) < 85)
                    key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
                else
                    key = {$urandom, $urandom};
                value = $urandom;
                send_request(mode, key, value, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 4) @(posedge clk);
        if (!mismatch_seen && pending_responses.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### fifo_evicting_request_cache_unit.f
hdl/ferc_pkg.sv
hdl/fifo_evicting_request_cache_unit.sv
hdl/ferc_checker.sv
tb/fifo_evicting_request_cache_unit_tb.sv
